// ===== hw/rtl/brm_pkg.sv =====
// Shared types and codes for the byte register machine execute block
`default_nettype none
package brm_pkg;
    typedef enum logic [4:0] {
        OP_MOV = 5'd0, OP_PUSH = 5'd1, OP_POP = 5'd2, OP_JMP = 5'd3, OP_CMP = 5'd4,
        OP_JE = 5'd5, OP_JA = 5'd6, OP_JAE = 5'd7, OP_JB = 5'd8, OP_JBE = 5'd9,
        OP_ADD = 5'd10, OP_SUB = 5'd11, OP_MUL = 5'd12, OP_DIV = 5'd13, OP_MOD = 5'd14,
        OP_SHL = 5'd15, OP_SHR = 5'd16, OP_OR = 5'd17, OP_AND = 5'd18, OP_XOR = 5'd19,
        OP_IN = 5'd20, OP_OUT = 5'd21
    } op_t;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_HALT      = 3'd1;
    localparam logic [2:0] ST_OVERFLOW  = 3'd2;
    localparam logic [2:0] ST_UNDERFLOW = 3'd3;
    localparam logic [2:0] ST_DIVZERO   = 3'd4;
    localparam logic [2:0] ST_ILLEGAL   = 3'd5;
    localparam logic [2:0] ST_BADREG    = 3'd6;

    localparam logic [1:0] CF_EQUAL = 2'd0;
    localparam logic [1:0] CF_BELOW = 2'd1;
    localparam logic [1:0] CF_ABOVE = 2'd2;

    localparam int unsigned DIV_STEPS = 8;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_EXEC, S_DIVIDE, S_WRITE, S_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture the input word
        logic read;      // read operands
        logic exec;      // evaluate and register the result
        logic div_start; // start the divider
        logic div_step;  // one restoring step
        logic commit;    // write the machine state
        logic clear;     // program load
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic needs_div;
        logic div_last;
    } sts_t;
endpackage
`default_nettype wire

// ===== hw/rtl/byte_register_machine_execute_top.sv =====
// Top level of the byte register machine execute block
// One instruction word in, one result word out. The word passes through the read,
// execute and write states before the result is presented; div and mod also pass
// through the divide state, whose restoring divider retires one quotient bit a cycle;
// the next word is taken only once the result is taken.
// A write of program_length clears the machine state.
`default_nettype none
module byte_register_machine_execute_top #(
    parameter int unsigned REG_COUNT   = 16,
    parameter int unsigned STACK_DEPTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [4:0]  command,
    input  wire logic        left_is_register,
    input  wire logic        right_is_register,
    input  wire logic [7:0]  left_operand,
    input  wire logic [7:0]  right_operand,
    input  wire logic [7:0]  input_byte,
    input  wire logic        input_available,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       status,
    output logic             output_valid,
    output logic [7:0]       output_value,
    output logic [7:0]       next_index,
    output logic             finished,
    input  wire logic        cfg_we,
    input  wire logic [8:0]  cfg_data
);
    brm_pkg::cmd_t cmd;
    brm_pkg::sts_t sts;

    brm_ctrl u_ctrl (
        .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .cfg_we,
        .sts, .cmd
    );

    brm_dp #(.REG_COUNT(REG_COUNT), .STACK_DEPTH(STACK_DEPTH)) u_dp (
        .clk, .rst_n, .cmd, .sts, .command, .left_is_register, .right_is_register,
        .left_operand, .right_operand, .input_byte, .input_available, .cfg_data,
        .status, .output_valid, .output_value, .next_index, .finished
    );
endmodule
`default_nettype wire

// ===== hw/rtl/brm_ctrl.sv =====
// Controller state machine for the execute block
`default_nettype none
module brm_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    input  wire logic          cfg_we,
    input  brm_pkg::sts_t      sts,
    output brm_pkg::cmd_t      cmd
);
    brm_pkg::state_t state_reg, state_next;

    // advance the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= brm_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            brm_pkg::S_IDLE:   if (in_valid) state_next = brm_pkg::S_READ;
            brm_pkg::S_READ:   state_next = brm_pkg::S_EXEC;
            brm_pkg::S_EXEC:   state_next = sts.needs_div ? brm_pkg::S_DIVIDE
                                                          : brm_pkg::S_WRITE;
            brm_pkg::S_DIVIDE: if (sts.div_last) state_next = brm_pkg::S_WRITE;
            brm_pkg::S_WRITE:  state_next = brm_pkg::S_OUT;
            brm_pkg::S_OUT:    if (out_ready) state_next = brm_pkg::S_IDLE;
            default:           state_next = brm_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        cmd.clear = cfg_we;
        case (state_reg)
            brm_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            brm_pkg::S_READ:   cmd.read = 1'b1;
            brm_pkg::S_EXEC:
            begin
                cmd.exec = 1'b1;
                cmd.div_start = sts.needs_div;
            end
            brm_pkg::S_DIVIDE: cmd.div_step = 1'b1;
            brm_pkg::S_WRITE:  cmd.commit = 1'b1;
            brm_pkg::S_OUT:    out_valid = 1'b1;
            default:           cmd = '0;
        endcase
    end
endmodule
`default_nettype wire

// ===== hw/rtl/brm_dp.sv =====
// Datapath: register file, stack, flag, index, ALU and divider
`default_nettype none
module brm_dp #(
    parameter int unsigned REG_COUNT   = 16,
    parameter int unsigned STACK_DEPTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  brm_pkg::cmd_t    cmd,
    output brm_pkg::sts_t    sts,
    input  wire logic [4:0]  command,
    input  wire logic        left_is_register,
    input  wire logic        right_is_register,
    input  wire logic [7:0]  left_operand,
    input  wire logic [7:0]  right_operand,
    input  wire logic [7:0]  input_byte,
    input  wire logic        input_available,
    input  wire logic [8:0]  cfg_data,
    output logic [2:0]       status,
    output logic             output_valid,
    output logic [7:0]       output_value,
    output logic [7:0]       next_index,
    output logic             finished
);
    localparam int unsigned RW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int unsigned SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int unsigned PW = $clog2(STACK_DEPTH + 1);
    localparam logic [8:0] REG_LIM = 9'(REG_COUNT);
    localparam logic [PW-1:0] SDEPTH = PW'(STACK_DEPTH);

    logic [7:0] rf_reg [REG_COUNT];
    logic [7:0] stk_reg [STACK_DEPTH];
    logic [PW-1:0] sp_reg;
    logic [1:0] cf_reg;
    logic [7:0] idx_reg;
    logic [8:0] plen_reg;

    // captured instruction word
    logic [4:0] op_reg;
    logic lreg_reg, rreg_reg, avail_reg;
    logic [7:0] lop_reg, rop_reg, ib_reg;
    logic [7:0] a_reg, b_reg, sv_reg, res_reg;
    logic [2:0] st_reg;
    logic wr_reg, wrsp_reg, ov_reg;
    logic [7:0] nidx_reg;
    logic [8:0] nxt9_reg;
    logic [7:0] q_reg;
    logic [7:0] rem_reg;
    logic [3:0] dcnt_reg;

    logic lok, rok;
    assign lok = {1'b0, lop_reg} < REG_LIM;
    assign rok = {1'b0, rop_reg} < REG_LIM;

    // hold the word and fetch operands
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= command;  lreg_reg <= left_is_register;
            rreg_reg <= right_is_register;  lop_reg <= left_operand;
            rop_reg <= right_operand;  ib_reg <= input_byte;
            avail_reg <= input_available;
        end
        if (cmd.read)
        begin
            a_reg <= lok ? rf_reg[lop_reg[RW-1:0]] : 8'd0;
            b_reg <= rreg_reg ? (rok ? rf_reg[rop_reg[RW-1:0]] : 8'd0) : rop_reg;
            sv_reg <= (sp_reg != '0 && sp_reg <= SDEPTH)
                      ? stk_reg[SW'(sp_reg - PW'(1))] : 8'd0;
        end
    end

    // evaluate one instruction
    logic [2:0] st_c;
    logic [7:0] r_c, la_c, nidx_c;
    logic wr_c, ov_c, take_c, isdiv_c;
    logic [7:0] prod_c;
    always_comb
    begin
        st_c = brm_pkg::ST_OK;  r_c = 8'd0;  wr_c = 1'b0;  ov_c = 1'b0;
        take_c = 1'b0;  nidx_c = idx_reg + 8'd1;
        la_c = lreg_reg ? a_reg : lop_reg;
        prod_c = a_reg * b_reg;
        isdiv_c = 1'b0;
        case (op_reg)
            brm_pkg::OP_MOV:
                if ((rreg_reg && !rok) || !lok) st_c = brm_pkg::ST_BADREG;
                else begin wr_c = 1'b1; r_c = b_reg; end
            brm_pkg::OP_PUSH:
                if (lreg_reg && !lok) st_c = brm_pkg::ST_BADREG;
                else if (sp_reg >= SDEPTH) st_c = brm_pkg::ST_OVERFLOW;
            brm_pkg::OP_POP:
                if (!lok) st_c = brm_pkg::ST_BADREG;
                else if (sp_reg == '0 || sp_reg > SDEPTH) st_c = brm_pkg::ST_UNDERFLOW;
                else begin wr_c = 1'b1; r_c = sv_reg; end
            brm_pkg::OP_JMP: take_c = 1'b1;
            brm_pkg::OP_CMP:
                if ((lreg_reg && !lok) || (rreg_reg && !rok)) st_c = brm_pkg::ST_BADREG;
            brm_pkg::OP_JE:  take_c = cf_reg == brm_pkg::CF_EQUAL;
            brm_pkg::OP_JA:  take_c = cf_reg == brm_pkg::CF_ABOVE;
            brm_pkg::OP_JAE: take_c = cf_reg == brm_pkg::CF_ABOVE
                                   || cf_reg == brm_pkg::CF_EQUAL;
            brm_pkg::OP_JB:  take_c = cf_reg == brm_pkg::CF_BELOW;
            brm_pkg::OP_JBE: take_c = cf_reg == brm_pkg::CF_BELOW
                                   || cf_reg == brm_pkg::CF_EQUAL;
            brm_pkg::OP_ADD, brm_pkg::OP_SUB, brm_pkg::OP_MUL, brm_pkg::OP_DIV,
            brm_pkg::OP_MOD, brm_pkg::OP_SHL, brm_pkg::OP_SHR, brm_pkg::OP_OR,
            brm_pkg::OP_AND, brm_pkg::OP_XOR:
                if ((rreg_reg && !rok) || !lok) st_c = brm_pkg::ST_BADREG;
                else if ((op_reg == brm_pkg::OP_DIV || op_reg == brm_pkg::OP_MOD)
                         && b_reg == 8'd0) st_c = brm_pkg::ST_DIVZERO;
                else
                begin
                    wr_c = 1'b1;
                    case (op_reg)
                        brm_pkg::OP_ADD: r_c = a_reg + b_reg;
                        brm_pkg::OP_SUB: r_c = a_reg - b_reg;
                        brm_pkg::OP_MUL: r_c = prod_c;
                        brm_pkg::OP_SHL: r_c = (b_reg >= 8'd8) ? 8'd0 : a_reg << b_reg[2:0];
                        brm_pkg::OP_SHR: r_c = (b_reg >= 8'd8) ? 8'd0 : a_reg >> b_reg[2:0];
                        brm_pkg::OP_OR:  r_c = a_reg | b_reg;
                        brm_pkg::OP_AND: r_c = a_reg & b_reg;
                        brm_pkg::OP_XOR: r_c = a_reg ^ b_reg;
                        default:         isdiv_c = 1'b1;
                    endcase
                end
            brm_pkg::OP_IN:
                if (!lok) st_c = brm_pkg::ST_BADREG;
                else if (!avail_reg) st_c = brm_pkg::ST_HALT;
                else begin wr_c = 1'b1; r_c = ib_reg; end
            brm_pkg::OP_OUT:
                if (lreg_reg && !lok) st_c = brm_pkg::ST_BADREG;
                else begin ov_c = 1'b1; r_c = la_c; end
            default: st_c = brm_pkg::ST_ILLEGAL;
        endcase
        if (take_c) nidx_c = lop_reg;
    end

    assign sts.needs_div = isdiv_c;
    assign sts.div_last = dcnt_reg == 4'(brm_pkg::DIV_STEPS - 1);

    // register the outcome; iterate the restoring divider
    logic [8:0] trial;
    assign trial = {rem_reg, q_reg[7]} - {1'b0, b_reg};
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            st_reg <= st_c;  res_reg <= r_c;  wr_reg <= wr_c && st_c == brm_pkg::ST_OK;
            wrsp_reg <= st_c == brm_pkg::ST_OK;  ov_reg <= ov_c;
            nidx_reg <= (st_c == brm_pkg::ST_OK) ? nidx_c : idx_reg;
            nxt9_reg <= (st_c == brm_pkg::ST_OK)
                        ? (take_c ? {1'b0, lop_reg} : {1'b0, idx_reg} + 9'd1)
                        : {1'b0, idx_reg};
        end
        if (cmd.div_start)
        begin
            q_reg <= a_reg;  rem_reg <= 8'd0;  dcnt_reg <= 4'd0;
        end
        else if (cmd.div_step)
        begin
            dcnt_reg <= dcnt_reg + 4'd1;
            if (!trial[8]) begin rem_reg <= trial[7:0]; q_reg <= {q_reg[6:0], 1'b1}; end
            else begin rem_reg <= {rem_reg[6:0], q_reg[7]}; q_reg <= {q_reg[6:0], 1'b0}; end
            if (sts.div_last)
                res_reg <= (op_reg == brm_pkg::OP_DIV)
                           ? (trial[8] ? {q_reg[6:0], 1'b0} : {q_reg[6:0], 1'b1})
                           : (trial[8] ? {rem_reg[6:0], q_reg[7]} : trial[7:0]);
        end
    end

    // commit machine state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++) rf_reg[i] <= 8'd0;
            for (int i = 0; i < STACK_DEPTH; i++) stk_reg[i] <= 8'd0;
            sp_reg <= '0;  cf_reg <= brm_pkg::CF_EQUAL;  idx_reg <= 8'd0;  plen_reg <= 9'd0;
        end
        else if (cmd.clear)
        begin
            for (int i = 0; i < REG_COUNT; i++) rf_reg[i] <= 8'd0;
            for (int i = 0; i < STACK_DEPTH; i++) stk_reg[i] <= 8'd0;
            sp_reg <= '0;  cf_reg <= brm_pkg::CF_EQUAL;  idx_reg <= 8'd0;
            plen_reg <= cfg_data;
        end
        else if (cmd.commit)
        begin
            idx_reg <= nidx_reg;
            if (wr_reg) rf_reg[lop_reg[RW-1:0]] <= res_reg;
            if (wrsp_reg && op_reg == brm_pkg::OP_PUSH)
            begin
                stk_reg[sp_reg[SW-1:0]] <= la_c;
                sp_reg <= sp_reg + PW'(1);
            end
            if (wrsp_reg && op_reg == brm_pkg::OP_POP) sp_reg <= sp_reg - PW'(1);
            if (wrsp_reg && op_reg == brm_pkg::OP_CMP)
                cf_reg <= (la_c == b_reg) ? brm_pkg::CF_EQUAL
                        : (la_c < b_reg) ? brm_pkg::CF_BELOW : brm_pkg::CF_ABOVE;
        end
    end

    // result word
    assign status       = st_reg;
    assign output_valid = ov_reg;
    assign output_value = ov_reg ? res_reg : 8'd0;
    assign next_index   = nidx_reg;
    assign finished     = nxt9_reg == plen_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/brm_checker.sv =====
// Port checker for the execute block, bound to the top level
`default_nettype none
module brm_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [2:0] status,
    input wire logic       output_valid,
    input wire logic [7:0] output_value
);
    // one word in flight
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("input taken while result pending");
    // a result never follows acceptance at once
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !out_valid) else $error("result too early");
    // emitted byte only on clean out
    a_out_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && output_valid) |-> status == brm_pkg::ST_OK)
        else $error("out with error");
    a_out_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !output_valid) |-> output_value == 8'd0) else $error("stray byte");
    // result holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(status)))
        else $error("result dropped");
endmodule

bind byte_register_machine_execute_top brm_checker u_brm_checker (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
    .status, .output_valid, .output_value
);
`default_nettype wire
